// ===== hdl/sild_pkg.sv =====
// Package for the serial image loader deframer.
// Holds the shared item type, frame characters and result status codes.
// No dependencies.
package sild_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ImgW    = 24;

  // Frame characters
  localparam logic [ByteW-1:0] CH_START    = 8'h4D;  // 'M'
  localparam logic [ByteW-1:0] CH_SIZE_END = 8'h43;  // 'C'
  localparam logic [ByteW-1:0] CH_HDR_END  = 8'h65;  // 'e'
  localparam logic [ByteW-1:0] CH_ZERO     = 8'h30;  // '0'

  localparam logic [AddrW-1:0] DEFAULT_BASE = 32'h0008_0000;

  // Result status codes
  localparam logic [StatusW-1:0] ST_HEADER = 2'd0;
  localparam logic [StatusW-1:0] ST_WRITE  = 2'd1;
  localparam logic [StatusW-1:0] ST_LAST   = 2'd2;
  localparam logic [StatusW-1:0] ST_ERROR  = 2'd3;

  // One received byte held in the input register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } sild_item_t;

endpackage

// ===== hdl/sild_in_stage.sv =====
// Input register stage of the deframer.
// Captures one received byte per transfer and holds it until the core takes it.
// Depends on sild_pkg.
module sild_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sild_pkg::ByteW-1:0]  in_rx_byte,
  input  logic                        core_ready,
  output sild_pkg::sild_item_t        item
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [sild_pkg::ByteW-1:0] byte_r;
  logic                       take;

  // Stall only while a held byte cannot move on
  assign in_stall  = valid_r & ~core_ready;
  assign take      = in_valid & ~in_stall;
  assign valid_nxt = take | (valid_r & ~core_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the byte on each accepted transfer
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

// ===== hdl/sild_core.sv =====
// Deframer core: header parser, payload address counter and result register.
// One byte is processed per cycle while the result register can take it; state advances as the result is registered.
// Depends on sild_pkg.
module sild_core #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sild_pkg::sild_item_t          item,
  output logic                          core_ready,
  input  logic [sild_pkg::AddrW-1:0]    load_base,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sild_pkg::StatusW-1:0]  out_status,
  output logic [sild_pkg::AddrW-1:0]    out_write_addr,
  output logic [sild_pkg::ByteW-1:0]    out_write_data,
  output logic [sild_pkg::ImgW-1:0]     out_image_size
);

  localparam int unsigned ExtW = (SIZE_BITS > sild_pkg::ImgW) ? SIZE_BITS : sild_pkg::ImgW;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_DIGITS,
    PH_WAIT_E,
    PH_PAYLOAD
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]           acc_r, acc_nxt, acc_upd;
  logic [SIZE_BITS-1:0]           cnt_r, cnt_nxt, cnt_inc;
  logic [SIZE_BITS-1:0]           acc_x10, digit;
  logic [ExtW-1:0]                acc_ext;
  logic                           restart;
  logic                           step;

  logic                           out_valid_r, out_valid_nxt;
  logic [sild_pkg::StatusW-1:0]   status_r, status_nxt;
  logic [sild_pkg::AddrW-1:0]     addr_r, addr_nxt;
  logic [sild_pkg::ByteW-1:0]     data_r, data_nxt;
  logic [sild_pkg::ImgW-1:0]      img_r, img_nxt;

  // Result register frees up when empty or drained this cycle
  assign core_ready = ~out_valid_r | ~out_stall;
  assign step       = item.valid & core_ready;

  // Shift-add for size*10, digit taken unchecked
  assign acc_x10 = (acc_r << 3) + (acc_r << 1);
  assign digit   = SIZE_BITS'(item.rx_byte) - SIZE_BITS'(sild_pkg::CH_ZERO);
  assign cnt_inc = cnt_r + 1'b1;

  // Parse one byte
  always_comb begin
    phase_nxt  = phase_r;
    acc_upd    = acc_r;
    cnt_nxt    = cnt_r;
    status_nxt = sild_pkg::ST_HEADER;
    addr_nxt   = '0;
    data_nxt   = '0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (item.rx_byte == sild_pkg::CH_START) begin
          phase_nxt = PH_SKIP;
        end else if (item.rx_byte == sild_pkg::CH_HDR_END) begin
          status_nxt = sild_pkg::ST_ERROR;
        end
      end
      PH_SKIP: begin
        if (item.rx_byte == sild_pkg::CH_HDR_END) begin
          status_nxt = sild_pkg::ST_ERROR;
        end else begin
          phase_nxt = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (item.rx_byte == sild_pkg::CH_SIZE_END) begin
          phase_nxt = PH_WAIT_E;
        end else if (item.rx_byte == sild_pkg::CH_HDR_END) begin
          status_nxt = sild_pkg::ST_ERROR;
        end else begin
          acc_upd = acc_x10 + digit;
        end
      end
      PH_WAIT_E: begin
        if (item.rx_byte == sild_pkg::CH_HDR_END) begin
          if (acc_r == '0) begin
            status_nxt = sild_pkg::ST_ERROR;
          end else begin
            phase_nxt = PH_PAYLOAD;
            cnt_nxt   = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        addr_nxt   = load_base + sild_pkg::AddrW'(cnt_r);
        data_nxt   = item.rx_byte;
        cnt_nxt    = cnt_inc;
        status_nxt = (cnt_inc == acc_r) ? sild_pkg::ST_LAST : sild_pkg::ST_WRITE;
      end
      default: begin
        phase_nxt = PH_SEARCH;
      end
    endcase
  end

  // Report size before any clear, then drop header state on last write or error
  assign acc_ext = ExtW'(acc_upd);
  assign img_nxt = acc_ext[sild_pkg::ImgW-1:0];
  assign restart = (status_nxt == sild_pkg::ST_LAST) || (status_nxt == sild_pkg::ST_ERROR);
  assign acc_nxt = restart ? '0 : acc_upd;

  assign out_valid_nxt = step | (out_valid_r & out_stall);

  // Hold parser state and the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEARCH;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r <= restart ? PH_SEARCH : phase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= restart ? '0 : cnt_nxt;
      end
    end
  end

  // Load the result payload on each step
  always_ff @(posedge clk) begin
    if (step) begin
      status_r <= status_nxt;
      addr_r   <= addr_nxt;
      data_r   <= data_nxt;
      img_r    <= img_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_write_addr = addr_r;
  assign out_write_data = data_r;
  assign out_image_size = img_r;

endmodule

// ===== hdl/serial_image_loader_deframer.sv =====
// Top level of the serial image loader deframer.
// Holds the load base register and connects sild_in_stage and sild_core; uses sild_pkg.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | in_rx_byte
//   out     | output    | out_valid/out_stall | status, write_addr, write_data, image_size
//   cfg     | input     | cfg_we            | cfg_wdata (load_base)
//
// One byte per cycle sustained while out_stall is low; each result passes the input register at the
// transfer edge, then the parse logic into the result register.
// Reset is synchronous, active low: header search, size and count cleared, base 0x80000.
// An out_stall holds the result register and backs up through the input register to in_stall.
module serial_image_loader_deframer #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sild_pkg::ByteW-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sild_pkg::StatusW-1:0]  out_status,
  output logic [sild_pkg::AddrW-1:0]    out_write_addr,
  output logic [sild_pkg::ByteW-1:0]    out_write_data,
  output logic [sild_pkg::ImgW-1:0]     out_image_size,
  input  logic                          cfg_we,
  input  logic [sild_pkg::AddrW-1:0]    cfg_wdata
);

  logic [sild_pkg::AddrW-1:0] load_base_r;
  sild_pkg::sild_item_t       item;
  logic                       core_ready;

  // Hold the load base address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r <= sild_pkg::DEFAULT_BASE;
    end else if (cfg_we) begin
      load_base_r <= cfg_wdata;
    end
  end

  sild_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .core_ready (core_ready),
    .item       (item)
  );

  sild_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .core_ready     (core_ready),
    .load_base      (load_base_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_image_size (out_image_size)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for serial_image_loader_deframer: drives framed and broken byte streams,
// predicts every result with an in-bench deframer and checks each transfer out.
// Depends on sild_pkg and the RTL under hdl/.
module tb_top;

  localparam int unsigned SizeBits  = 24;
  localparam int unsigned PipeDepth = 2;
  localparam int unsigned DrainMax  = 20000;
  localparam int unsigned ByteGoal  = 1800;

  // Header hunt states of the predictor
  typedef enum logic [2:0] {
    HUNT_START,
    HUNT_SKIP,
    HUNT_DIGITS,
    HUNT_END,
    LOADING
  } hunt_t;

  typedef struct {
    logic [sild_pkg::StatusW-1:0] status;
    logic [sild_pkg::AddrW-1:0]   addr;
    logic [sild_pkg::ByteW-1:0]   data;
    logic [sild_pkg::ImgW-1:0]    size;
  } loader_event_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [sild_pkg::ByteW-1:0]   in_rx_byte;
  logic                         out_valid;
  logic                         out_stall;
  logic [sild_pkg::StatusW-1:0] out_status;
  logic [sild_pkg::AddrW-1:0]   out_write_addr;
  logic [sild_pkg::ByteW-1:0]   out_write_data;
  logic [sild_pkg::ImgW-1:0]    out_image_size;
  logic                         cfg_we;
  logic [sild_pkg::AddrW-1:0]   cfg_wdata;

  // Predictor state
  hunt_t                      hunt;
  logic [SizeBits-1:0]        size_acc;
  logic [SizeBits-1:0]        load_count;
  logic [sild_pkg::AddrW-1:0] base_reg;

  loader_event_t loader_events[$];

  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned frames_loaded;
  int unsigned writes_seen;
  int unsigned header_errors;
  int unsigned base_writes;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_on;

  serial_image_loader_deframer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_image_size (out_image_size),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Advance the deframer by one byte and return the result it produces
  function automatic loader_event_t deframe_byte(input logic [sild_pkg::ByteW-1:0] b);
    loader_event_t ev;
    ev.status = sild_pkg::ST_HEADER;
    ev.addr   = '0;
    ev.data   = '0;
    case (hunt)
      HUNT_START: begin
        if (b == sild_pkg::CH_START) begin
          hunt = HUNT_SKIP;
        end else if (b == sild_pkg::CH_HDR_END) begin
          ev.status = sild_pkg::ST_ERROR;
        end
      end
      HUNT_SKIP: begin
        if (b == sild_pkg::CH_HDR_END) begin
          ev.status = sild_pkg::ST_ERROR;
        end else begin
          hunt = HUNT_DIGITS;
        end
      end
      HUNT_DIGITS: begin
        if (b == sild_pkg::CH_SIZE_END) begin
          hunt = HUNT_END;
        end else if (b == sild_pkg::CH_HDR_END) begin
          ev.status = sild_pkg::ST_ERROR;
        end else begin
          size_acc = size_acc * SizeBits'(10)
                   + (SizeBits'(b) - SizeBits'(sild_pkg::CH_ZERO));
        end
      end
      HUNT_END: begin
        if (b == sild_pkg::CH_HDR_END) begin
          if (size_acc == '0) begin
            ev.status = sild_pkg::ST_ERROR;
          end else begin
            hunt       = LOADING;
            load_count = '0;
          end
        end
      end
      default: begin
        ev.addr    = base_reg + sild_pkg::AddrW'(load_count);
        ev.data    = b;
        load_count = load_count + 1'b1;
        ev.status  = (load_count == size_acc) ? sild_pkg::ST_LAST : sild_pkg::ST_WRITE;
      end
    endcase
    ev.size = sild_pkg::ImgW'(size_acc);
    // Drop back to the header search after a last write or an error
    if (ev.status == sild_pkg::ST_LAST || ev.status == sild_pkg::ST_ERROR) begin
      hunt       = HUNT_START;
      size_acc   = '0;
      load_count = '0;
    end
    return ev;
  endfunction

  function automatic logic [sild_pkg::ByteW-1:0] pick_byte_not(
      input logic [sild_pkg::ByteW-1:0] a,
      input logic [sild_pkg::ByteW-1:0] b);
    logic [sild_pkg::ByteW-1:0] v;
    do begin
      v = sild_pkg::ByteW'($urandom_range(0, 255));
    end while (v == a || v == b);
    return v;
  endfunction

  // Offer one byte, after a random gap when tx_idle is set, and hold it until the transfer
  task automatic send_byte(input logic [sild_pkg::ByteW-1:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      in_rx_byte <= sild_pkg::ByteW'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    loader_events.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // Pause the sender until every predicted result has been checked
  task automatic wait_results_done();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (loader_events.size() != 0 && guard < DrainMax) begin
      @(posedge clk);
      guard++;
    end
    if (loader_events.size() != 0) begin
      $error("results still missing after drain: %0d", loader_events.size());
      err_count++;
    end
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  task automatic set_load_base(input logic [sild_pkg::AddrW-1:0] v);
    wait_results_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    base_reg = v;
    base_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send a frame: start, skip byte, leading zeros, decimal size, size end, fillers, end, payload
  task automatic send_frame(input int unsigned size, input int unsigned zeros,
                            input int unsigned fillers);
    string digits;
    digits = $sformatf("%0d", size);
    send_byte(sild_pkg::CH_START);
    send_byte(pick_byte_not(sild_pkg::CH_HDR_END, sild_pkg::CH_HDR_END));
    repeat (zeros) send_byte(sild_pkg::CH_ZERO);
    for (int i = 0; i < digits.len(); i++) begin
      send_byte(digits[i]);
    end
    send_byte(sild_pkg::CH_SIZE_END);
    repeat (fillers) send_byte(pick_byte_not(sild_pkg::CH_HDR_END, sild_pkg::CH_HDR_END));
    send_byte(sild_pkg::CH_HDR_END);
    repeat (size) send_byte(sild_pkg::ByteW'($urandom_range(0, 255)));
  endtask

  // Send a header that never reaches the size end and abort it with an early end
  task automatic send_broken_header(input int unsigned len);
    send_byte(sild_pkg::CH_START);
    repeat (len) send_byte(pick_byte_not(sild_pkg::CH_SIZE_END, sild_pkg::CH_SIZE_END));
    send_byte(sild_pkg::CH_HDR_END);
  endtask

  // Check each result transfer and pace the receiver
  initial begin : result_check
    int unsigned   stall_left;
    loader_event_t want;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
        if (loader_events.size() == 0) begin
          $error("result with nothing expected: status %0d", out_status);
          err_count++;
        end else begin
          want = loader_events.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_count++;
          end
          if (out_write_addr !== want.addr) begin
            $error("write_addr: expected %h, got %h", want.addr, out_write_addr);
            err_count++;
          end
          if (out_write_data !== want.data) begin
            $error("write_data: expected %h, got %h", want.data, out_write_data);
            err_count++;
          end
          if (out_image_size !== want.size) begin
            $error("image_size: expected %0d, got %0d", want.size, out_image_size);
            err_count++;
          end
        end
        if (out_status == sild_pkg::ST_LAST) frames_loaded++;
        if (out_status == sild_pkg::ST_LAST || out_status == sild_pkg::ST_WRITE) writes_seen++;
        if (out_status == sild_pkg::ST_ERROR) header_errors++;
        stall_left = rx_idle ? $urandom_range(0, 15) : 0;
      end
      @(negedge clk);
      out_stall <= hold_on || (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic test_default_base();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_frame(1, 0, 1);
  endtask

  task automatic test_header_errors();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // Early end while searching, stray size end while searching
    send_byte(sild_pkg::CH_HDR_END);
    send_byte(sild_pkg::CH_SIZE_END);
    // Early end in the skipped byte
    send_byte(sild_pkg::CH_START);
    send_byte(sild_pkg::CH_HDR_END);
    // Early end among the size digits
    send_byte(sild_pkg::CH_START);
    send_byte("1");
    send_byte(sild_pkg::CH_HDR_END);
    // Header with an empty, hence zero, size
    send_byte(sild_pkg::CH_START);
    send_byte("x");
    send_byte(sild_pkg::CH_SIZE_END);
    send_byte(sild_pkg::CH_HDR_END);
  endtask

  task automatic test_size_wrap();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    // Non-digit size bytes wrap the accumulator; abort to see it in image_size
    send_byte(sild_pkg::CH_START);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sild_pkg::CH_HDR_END);
  endtask

  task automatic test_address_wrap();
    set_load_base(32'hFFFF_FFFF);
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    send_frame(2, 0, 0);
  endtask

  task automatic test_backpressure();
    set_load_base(32'h0000_1000);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // Hold the receiver off while the sender keeps offering bytes
    fork
      begin
        hold_on = 1'b1;
        repeat (300) @(posedge clk);
        hold_on = 1'b0;
      end
      send_frame(40, 1, 2);
    join
    wait_results_done();
  endtask

  task automatic test_random_frames();
    int unsigned pick;
    int unsigned size;
    int unsigned frame_no;
    frame_no = 0;
    while (bytes_sent < ByteGoal) begin
      // Change the base between frames, extremes included
      if (frame_no % 8 == 7) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       set_load_base(32'h0000_0000);
          1:       set_load_base(32'hFFFF_FFFF);
          2:       set_load_base(32'hFFFF_FFF0);
          default: set_load_base(sild_pkg::AddrW'($urandom));
        endcase
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // Leading noise in the search state
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(pick_byte_not(sild_pkg::CH_START, sild_pkg::CH_SIZE_END));
        end
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 400)
                                           : $urandom_range(1, 24);
        send_frame(size, $urandom_range(0, 1), $urandom_range(0, 3));
      end else if (pick < 9) begin
        send_broken_header($urandom_range(0, 6));
      end else begin
        send_frame(0, $urandom_range(0, 2), $urandom_range(0, 2));
      end
      frame_no++;
    end
  endtask

  initial begin : run_tests
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    hold_on    = 1'b0;
    err_count     = 0;
    bytes_sent    = 0;
    frames_loaded = 0;
    writes_seen   = 0;
    header_errors = 0;
    base_writes   = 0;
    hunt       = HUNT_START;
    size_acc   = '0;
    load_count = '0;
    base_reg   = sild_pkg::DEFAULT_BASE;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_default_base();
    test_header_errors();
    test_size_wrap();
    test_address_wrap();
    test_backpressure();
    test_random_frames();
    set_load_base(sild_pkg::DEFAULT_BASE);
    send_frame(3, 0, 0);

    wait_results_done();
    repeat (PipeDepth * 4) @(posedge clk);
    if (loader_events.size() != 0) begin
      $error("%0d expected results never arrived", loader_events.size());
      err_count++;
    end
    $display("Sent %0d bytes: %0d images loaded, %0d payload writes, %0d header errors,",
             bytes_sent, frames_loaded, writes_seen, header_errors);
    $display("%0d load base writes, with random gaps, stalls and a long receiver hold-off.",
             base_writes);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // End a hung run
  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sild_pkg.sv
hdl/sild_in_stage.sv
hdl/sild_core.sv
hdl/serial_image_loader_deframer.sv
tb/tb_top.sv
